FILE: hdl/urvld_pkg.sv
// Shared types and constants of the unary-run VLC level decoder.
package urvld_pkg;

   localparam int COEFFS_PER_BLOCK = 63;
   localparam int SIZE_CLASSES     = 12;
   localparam int RUN_LIMIT        = 63;

   localparam logic [11:0] BPF_RESET = 12'd864;

   // size code tree nodes; nodes 4 and up count a chain of leading ones
   localparam logic [3:0] NODE_ROOT     = 4'd0;
   localparam logic [3:0] NODE_ZERO     = 4'd1;
   localparam logic [3:0] NODE_ONE      = 4'd2;
   localparam logic [3:0] NODE_ONE_ZERO = 4'd3;
   localparam logic [3:0] NODE_ONES_MAX = 4'd11;

   typedef enum logic [1:0] {
      PH_RUN,
      PH_PREFIX,
      PH_AMP
   } phase_type;

   typedef enum logic [2:0] {
      KIND_COEFF    = 3'd0,
      KIND_EOB      = 3'd1,
      KIND_POS_OVF  = 3'd2,
      KIND_RUN_LONG = 3'd3,
      KIND_TRUNC    = 3'd4
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [6:0]  run_count;
      logic [3:0]  prefix_node;
      logic [3:0]  size_class;
      logic [10:0] amp_acc;
      logic [3:0]  amp_left;
      logic [5:0]  position;
      logic [11:0] block_counter;
      logic        finished;
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [11:0] level;
      logic [5:0]         coeff_position;
      logic [5:0]         run_length;
      logic [11:0]        block_number;
      logic               block_last;
      logic               stream_done;
   } result_type;

endpackage

FILE: hdl/urvld_req_if.sv
// Input channel: one stream bit per item.
interface urvld_req_if;
   logic valid;
   logic ready;
   logic in_bit;
   logic in_last;

   modport source (output valid, output in_bit, output in_last, input ready);
   modport sink (input valid, input in_bit, input in_last, output ready);
endinterface

FILE: hdl/urvld_rsp_if.sv
// Result channel: one decoded event per item.
interface urvld_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [11:0] level;
   logic [5:0]         coeff_position;
   logic [5:0]         run_length;
   logic [11:0]        block_number;
   logic               block_last;
   logic               stream_done;

   modport source (output valid, output kind, output level, output coeff_position,
                   output run_length, output block_number, output block_last,
                   output stream_done, input ready);
   modport sink (input valid, input kind, input level, input coeff_position,
                 input run_length, input block_number, input block_last,
                 input stream_done, output ready);
endinterface

FILE: hdl/urvld_csr_if.sv
// Configuration write channel for the blocks-per-frame register.
interface urvld_csr_if;
   logic        valid;
   logic        ready;
   logic [11:0] blocks_per_frame;

   modport source (output valid, output blocks_per_frame, input ready);
   modport sink (input valid, input blocks_per_frame, output ready);
endinterface

FILE: hdl/urvld_step.sv
// Next-state and result logic for one stream bit.
module urvld_step
   import urvld_pkg::*;
(
   input  state_type   st,
   input  logic        in_bit,
   input  logic        in_last,
   input  logic [11:0] blocks_per_frame,
   output state_type   nxt,
   output result_type  res,
   output logic        has_result
);

   logic        ev;
   kind_type    kind;
   logic        closes;
   logic [11:0] lvl;
   logic [5:0]  cpos;
   logic        size_hit;
   logic [3:0]  size_val;
   logic [10:0] acc;
   logic [3:0]  left;
   logic [3:0]  sz;
   logic [6:0]  p;
   logic [6:0]  pos1;
   logic [11:0] bc1;

   always_comb begin
      nxt      = st;
      ev       = 1'b0;
      kind     = KIND_COEFF;
      closes   = 1'b0;
      lvl      = '0;
      cpos     = '0;
      size_hit = 1'b0;
      size_val = '0;
      acc      = '0;
      left     = '0;
      sz       = 4'd1;
      p        = '0;
      pos1     = '0;
      bc1      = st.block_counter + 12'd1;

      if (!st.finished) begin
         case (st.phase)
            PH_RUN: begin
               if (in_bit) begin
                  nxt.run_count = st.run_count + 7'd1;
                  if (nxt.run_count > 7'(RUN_LIMIT)) begin
                     ev     = 1'b1;
                     kind   = KIND_RUN_LONG;
                     closes = 1'b1;
                  end
               end else begin
                  nxt.phase       = PH_PREFIX;
                  nxt.prefix_node = NODE_ROOT;
               end
            end
            PH_PREFIX: begin
               case (st.prefix_node)
                  NODE_ROOT: nxt.prefix_node = in_bit ? NODE_ONE : NODE_ZERO;
                  NODE_ZERO: begin
                     size_hit = 1'b1;
                     size_val = in_bit ? 4'd2 : 4'd1;
                  end
                  NODE_ONE: nxt.prefix_node = in_bit ? 4'd4 : NODE_ONE_ZERO;
                  NODE_ONE_ZERO: begin
                     if (in_bit) begin
                        size_hit = 1'b1;
                        size_val = 4'd3;
                     end else begin
                        // size zero: end of block
                        ev     = 1'b1;
                        kind   = KIND_EOB;
                        closes = 1'b1;
                     end
                  end
                  default: begin
                     if (st.prefix_node > NODE_ONES_MAX) begin
                        ev     = 1'b1;
                        kind   = KIND_EOB;
                        closes = 1'b1;
                     end else if (!in_bit) begin
                        size_hit = 1'b1;
                        size_val = st.prefix_node;
                     end else if (st.prefix_node == NODE_ONES_MAX) begin
                        // ten ones: invalid code, closes as end of block
                        ev     = 1'b1;
                        kind   = KIND_EOB;
                        closes = 1'b1;
                     end else begin
                        nxt.prefix_node = st.prefix_node + 4'd1;
                     end
                  end
               endcase
               if (size_hit) begin
                  if (size_val >= 4'(SIZE_CLASSES)) begin
                     ev     = 1'b1;
                     kind   = KIND_EOB;
                     closes = 1'b1;
                  end else begin
                     nxt.size_class = size_val;
                     nxt.amp_left   = size_val;
                     nxt.amp_acc    = '0;
                     nxt.phase      = PH_AMP;
                  end
               end
            end
            PH_AMP: begin
               acc          = {st.amp_acc[9:0], in_bit};
               left         = st.amp_left - ((st.amp_left != 4'd0) ? 4'd1 : 4'd0);
               nxt.amp_acc  = acc;
               nxt.amp_left = left;
               if (left == 4'd0) begin
                  sz = st.size_class;
                  if (sz < 4'd1)  sz = 4'd1;
                  if (sz > 4'd11) sz = 4'd11;
                  // JPEG sign extension: small values stand for negatives
                  if (acc < (11'd1 << (sz - 4'd1)))
                     lvl = {1'b0, acc} - (12'd1 << sz) + 12'd1;
                  else
                     lvl = {1'b0, acc};
                  p = {1'b0, st.position} + st.run_count;
                  ev = 1'b1;
                  if (p >= 7'(COEFFS_PER_BLOCK)) begin
                     kind   = KIND_POS_OVF;
                     closes = 1'b1;
                     lvl    = '0;
                  end else begin
                     kind         = KIND_COEFF;
                     cpos         = p[5:0];
                     pos1         = p + 7'd1;
                     nxt.position = pos1[5:0];
                     closes       = (pos1 >= 7'(COEFFS_PER_BLOCK));
                  end
               end
            end
            default: nxt = st;
         endcase

         if (!ev && in_last) begin
            ev     = 1'b1;
            kind   = KIND_TRUNC;
            closes = 1'b1;
         end
      end

      res.kind           = kind;
      res.level          = lvl;
      res.coeff_position = cpos;
      res.run_length     = (nxt.run_count > 7'd63) ? 6'd63 : nxt.run_count[5:0];
      res.block_number   = st.block_counter;
      res.block_last     = closes;
      res.stream_done    = 1'b0;

      if (ev) begin
         if (closes) begin
            nxt.position      = '0;
            nxt.block_counter = bc1;
            if (bc1 == blocks_per_frame) nxt.finished = 1'b1;
         end
         if (in_last) nxt.finished = 1'b1;
         nxt.phase       = PH_RUN;
         nxt.run_count   = '0;
         nxt.prefix_node = NODE_ROOT;
         nxt.size_class  = '0;
         nxt.amp_acc     = '0;
         nxt.amp_left    = '0;
      end
      res.stream_done = nxt.finished;
      has_result      = ev;
   end

endmodule

FILE: hdl/unary_run_vlc_level_decoder.sv
// Top level of the unary-run VLC level decoder.
//
//  channel | direction | carries
//  --------+-----------+------------------------------------------------------
//  req     | in        | in_bit, in_last: one stream bit per item
//  rsp     | out       | kind, level, coeff_position, run_length, block_number,
//          |           | block_last, stream_done: zero or one item per bit
//  csr     | in        | blocks_per_frame write, always ready
//
// One bit per cycle sustained while rsp is not stalled; a bit's result is presented on rsp
// after the bit passes the input register and is decoded into the result register.
// Decode state updates once per decoded bit, so bits never wait on each other.
// A stalled rsp holds its item; the one-entry input register takes one more bit,
// then req.ready drops until rsp is taken.
// Synchronous reset clears the decode state and sets blocks_per_frame to 864.
module unary_run_vlc_level_decoder
   import urvld_pkg::*;
(
   input logic         clock,
   input logic         reset,
   urvld_req_if.sink   req,
   urvld_rsp_if.source rsp,
   urvld_csr_if.sink   csr
);

   state_type   state_ff;
   state_type   state_in;
   result_type  rsp_ff;
   result_type  rsp_in;
   logic        has_result;
   logic        in_valid_ff;
   logic        in_bit_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff;
   logic [11:0] bpf_ff;
   logic        go;

   assign go        = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || go;
   assign csr.ready = 1'b1;

   urvld_step u_step (
      .st               (state_ff),
      .in_bit           (in_bit_ff),
      .in_last          (in_last_ff),
      .blocks_per_frame (bpf_ff),
      .nxt              (state_in),
      .res              (rsp_in),
      .has_result       (has_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bpf_ff       <= BPF_RESET;
         state_ff     <= '{phase: PH_RUN, prefix_node: NODE_ROOT, default: '0};
      end else begin
         if (req.valid && req.ready)
            in_valid_ff <= 1'b1;
         else if (go)
            in_valid_ff <= 1'b0;
         if (go) begin
            state_ff     <= state_in;
            rsp_valid_ff <= has_result;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr.valid)
            bpf_ff <= csr.blocks_per_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_bit_ff  <= req.in_bit;
         in_last_ff <= req.in_last;
      end
      if (go && has_result)
         rsp_ff <= rsp_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_ff.kind;
   assign rsp.level          = rsp_ff.level;
   assign rsp.coeff_position = rsp_ff.coeff_position;
   assign rsp.run_length     = rsp_ff.run_length;
   assign rsp.block_number   = rsp_ff.block_number;
   assign rsp.block_last     = rsp_ff.block_last;
   assign rsp.stream_done    = rsp_ff.stream_done;

`ifndef SYNTH
   a_finished_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.finished |=> state_ff.finished)
      else $error("finished flag dropped without reset");

   a_no_item_after_done: assert property (@(posedge clock) disable iff (reset)
      (go && state_ff.finished) |=> !rsp_valid_ff)
      else $error("item produced after stream finished");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.position < 6'(COEFFS_PER_BLOCK))
      else $error("position left the block");

   a_noncoeff_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind != KIND_COEFF)
         |-> (rsp_ff.level == 12'sd0 && rsp_ff.coeff_position == 6'd0
              && rsp_ff.block_last))
      else $error("non-coefficient item carries level or position");

   a_run_long_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_RUN_LONG) |-> rsp_ff.run_length == 6'd63)
      else $error("run-too-long item without saturated run");
`endif

endmodule
